// ===== rtl/olar_pkg.sv =====
// ----------------------------------------------------------------------------
// olar_pkg: shared definitions for the ordered list
// Capacity, index widths, request and status codes, and the result record.
// ----------------------------------------------------------------------------
package olar_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 16;

  // Width of an entry address and of the entry count.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int VAL_W = 32;
  localparam int POS_W = 4;
  localparam int OUT_CNT_W = 5;

  // Request opcodes.
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [OUT_CNT_W-1:0]    entry_count;
  } res_t;

  // The count field carries the low bits of the entry count.
  function automatic logic [OUT_CNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] w;
    w = (CNT_W + OUT_CNT_W)'(c);
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/ordered_list_append_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_list_append_remove: fixed-capacity list in insertion order
// Append at the tail, remove the first matching entry, get by position.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   -------------------------------------
//   request   in_valid / in_stall  opcode, value, position
//   result    out_valid/out_stall  status, read_value, entry_count
//
// Steps: append, an unused opcode and a get past the tail go straight to the
// result state; a get first waits in ST_GETW on the memory read. A remove of a
// non-empty list steps through ST_SCAN once per entry scanned and ST_SHIFT once
// per entry moved down, as the entry memory has one read and one write port.
// One request is worked on at a time.
// Reset clears the entry count and the control state; the entry memory is
// not cleared, as only entries below the count are ever read.
// A result waits in its own register while out_stall is high, and the next
// request is still taken and worked until it has a result of its own.
// ----------------------------------------------------------------------------
module ordered_list_append_remove (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic signed [olar_pkg::VAL_W-1:0] value,
  input  logic [olar_pkg::POS_W-1:0]        position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [olar_pkg::VAL_W-1:0] read_value,
  output logic [olar_pkg::OUT_CNT_W-1:0]    entry_count
);
  import olar_pkg::*;

  // Handoff from the sequencer to the result register.
  logic push;
  logic push_ok;
  res_t res;

  // The sequencer owns the entry memory and the count; it raises push once
  // per request when its result is ready and the result register can take it.
  olar_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .value    (value),
    .position (position),
    .push_ok  (push_ok),
    .push     (push),
    .res      (res)
  );

  // The result register decouples the consumer's stall from the sequencer.
  olar_resq u_resq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_ok     (push_ok),
    .res         (res),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

endmodule

// ===== rtl/olar_engine.sv =====
// ----------------------------------------------------------------------------
// olar_engine: entry memory and request sequencer
// Holds the entries in a synchronous memory and runs append, the
// search-and-close-up of remove, and get through read-modify-write steps.
// ----------------------------------------------------------------------------
module olar_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic signed [olar_pkg::VAL_W-1:0] value,
  input  logic [olar_pkg::POS_W-1:0]    position,
  input  logic                          push_ok,
  output logic                          push,
  output olar_pkg::res_t                res
);
  import olar_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_GETW  = 5'b01000,
    ST_RES   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic signed [VAL_W-1:0] match_val;
  res_t res_next;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             we;

  logic [CNT_W-1:0]       idx_ext, idx_p1, idx_p2;
  logic [CNT_W+POS_W-1:0] pos_ext, cnt_ext;

  assign idx_ext = CNT_W'(idx);
  assign idx_p1  = idx_ext + CNT_W'(1);
  assign idx_p2  = idx_ext + CNT_W'(2);
  assign pos_ext = (CNT_W + POS_W)'(position);
  assign cnt_ext = (CNT_W + POS_W)'(count);

  assign in_stall = (state != ST_IDLE);
  assign push     = (state == ST_RES) && push_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    res_next   = res;
    rd_addr    = idx;
    we         = 1'b0;
    wr_addr    = idx;
    wr_data    = rd_data;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_next.read_value  = '0;
          res_next.status      = ST_NONE;
          res_next.entry_count = count_field(count);
          state_next           = ST_RES;
          case (opcode)
            OP_APPEND: begin
              if (count < CNT_W'(CAPACITY)) begin
                we                   = 1'b1;
                wr_addr              = IDX_W'(count);
                wr_data              = value;
                count_next           = count + CNT_W'(1);
                res_next.status      = ST_DONE;
                res_next.entry_count = count_field(count + CNT_W'(1));
              end else begin
                res_next.status = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (count != '0) begin
                rd_addr    = '0;
                idx_next   = '0;
                state_next = ST_SCAN;
              end
            end
            OP_GET: begin
              if (pos_ext < cnt_ext) begin
                rd_addr    = pos_ext[IDX_W-1:0];
                state_next = ST_GETW;
              end
            end
            default: begin
              res_next.status = ST_NONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_data == match_val) begin
          if (idx_p1 < count) begin
            rd_addr    = IDX_W'(idx_p1);
            state_next = ST_SHIFT;
          end else begin
            count_next           = count - CNT_W'(1);
            res_next.status      = ST_DONE;
            res_next.entry_count = count_field(count - CNT_W'(1));
            state_next           = ST_RES;
          end
        end else if (idx_p1 < count) begin
          rd_addr  = IDX_W'(idx_p1);
          idx_next = IDX_W'(idx_p1);
        end else begin
          state_next = ST_RES;
        end
      end
      ST_SHIFT: begin
        // Entry idx+1 is on the read port; move it down one place.
        we      = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        if (idx_p2 < count) begin
          rd_addr  = IDX_W'(idx_p2);
          idx_next = IDX_W'(idx_p1);
        end else begin
          count_next           = count - CNT_W'(1);
          res_next.status      = ST_DONE;
          res_next.entry_count = count_field(count - CNT_W'(1));
          state_next           = ST_RES;
        end
      end
      ST_GETW: begin
        res_next.status     = ST_DONE;
        res_next.read_value = rd_data;
        state_next          = ST_RES;
      end
      ST_RES: begin
        if (push_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx <= idx_next;
    res <= res_next;
    if (state == ST_IDLE && in_valid) begin
      match_val <= value;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_IDLE && opcode == OP_APPEND) || state == ST_SHIFT)
    else $error("memory write outside append or close-up");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |->
      count == $past(count) + CNT_W'(1) || count + CNT_W'(1) == $past(count))
    else $error("entry count moved by more than one");

  a_dec_remove: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count < $past(count) |->
      $past(state == ST_SCAN) || $past(state == ST_SHIFT))
    else $error("entry count dropped outside a remove");

endmodule

// ===== rtl/olar_resq.sv =====
// ----------------------------------------------------------------------------
// olar_resq: result holding register
// Keeps one finished result for the consumer so the sequencer can move on.
// ----------------------------------------------------------------------------
module olar_resq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              push_ok,
  input  olar_pkg::res_t                    res,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [olar_pkg::VAL_W-1:0] read_value,
  output logic [olar_pkg::OUT_CNT_W-1:0]    entry_count
);
  import olar_pkg::*;

  logic full;
  res_t held;
  logic take;

  assign take      = full && !out_stall;
  assign push_ok   = !full || take;
  assign out_valid = full;

  assign status      = held.status;
  assign read_value  = held.read_value;
  assign entry_count = held.entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
    if (push) begin
      held <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || !out_stall)
    else $error("result overwritten while still held");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    push |=> full)
    else $error("pushed result not held");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    take && !push |=> !full)
    else $error("taken result still held");

endmodule

// ===== test/tb_ordered_list_append_remove.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_append_remove: self-checking bench for the ordered list
// A mirror of the list predicts the result of every accepted request. Each
// result that comes out is compared field by field with the oldest
// prediction. A directed run covers the edge cases, then a long random run
// fills and drains the list, with random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ordered_list_append_remove;
  import olar_pkg::*;

  // The opcode that the block does not define; it must change nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int HOLD_AT         = 350;   // request count that starts the long hold
  localparam int HOLD_CYCLES     = 400;   // length of the long receiver hold
  localparam int QUIET_FROM      = 700;   // no idling on either side in this window
  localparam int QUIET_TO        = 900;
  localparam int CYCLE_LIMIT     = 400000;

  // --------------------------------------------------------------------------
  // Mirror of the list. It keeps its own copy of the entries and the count,
  // works out the result of each accepted request, and holds those results
  // in order until the block delivers them.
  // --------------------------------------------------------------------------
  class list_mirror;
    logic signed [VAL_W-1:0] entries [CAPACITY];
    int unsigned             held;
    res_t                    due_results [$];
    int unsigned             errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function void note_request(logic [1:0] op, logic signed [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
      res_t r;
      int   hit;
      r.status     = ST_NONE;
      r.read_value = '0;
      case (op)
        OP_APPEND: begin
          if (held >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            entries[held] = val;
            held++;
            r.status = ST_DONE;
          end
        end
        OP_REMOVE: begin
          // Find the first match from the head, then close the gap behind it.
          hit = -1;
          for (int i = 0; i < held; i++) begin
            if (hit < 0 && entries[i] == val) hit = i;
          end
          if (hit >= 0) begin
            for (int i = hit; i + 1 < held; i++) entries[i] = entries[i + 1];
            held--;
            r.status = ST_DONE;
          end
        end
        OP_GET: begin
          if (pos < held && pos < CAPACITY) begin
            r.read_value = entries[pos];
            r.status     = ST_DONE;
          end
        end
        default: begin
        end
      endcase
      r.entry_count = OUT_CNT_W'(held);
      due_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [VAL_W-1:0] rd,
                               logic [OUT_CNT_W-1:0] cnt);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result with no request pending: status %0d, read_value %0d, count %0d",
               st, rd, cnt);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (st !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (rd !== want.read_value) begin
        $error("read_value mismatch: expected %0d, actual %0d", want.read_value, rd);
        errors++;
      end
      if (cnt !== want.entry_count) begin
        $error("entry_count mismatch: expected %0d, actual %0d", want.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [1:0]              opcode     = OP_APPEND;
  logic signed [VAL_W-1:0] value      = '0;
  logic [POS_W-1:0]        position   = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] read_value;
  logic [OUT_CNT_W-1:0]    entry_count;

  list_mirror mirror = new();

  int  sent       = 0;     // requests accepted so far
  int  cycles     = 0;
  int  hold_left  = 0;
  bit  hold_used  = 1'b0;
  wire quiet      = (sent >= QUIET_FROM) && (sent < QUIET_TO);

  ordered_list_append_remove i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side. A result is taken at an edge where out_valid is high and
  // out_stall is low; the values sampled here are the ones from before the
  // edge, the same ones the block saw. The stall for the next cycle is then
  // chosen: once, a long hold that lets the block fill up and push back on
  // its request side, otherwise random stalls except in the quiet window.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      mirror.check_result(status, read_value, entry_count);
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_used && sent >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 23);
    end
  end

  // Offers one request and waits until the block takes it. Outside the quiet
  // window the request side may first go idle, so that gaps land on every
  // phase of the block's work.
  task automatic send_request(input logic [1:0] op, input logic signed [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_request(op, val, pos);
    sent++;
  endtask

  // A small set of values that recur, so that removals often hit duplicates.
  function automatic logic signed [VAL_W-1:0] common_value();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      4:       return 32'sd1;
      5:       return 32'sd5;
      6:       return 32'sh5555_AAAA;
      default: return 32'shAAAA_5555;
    endcase
  endfunction

  initial begin
    logic [1:0]              op;
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] last_val;
    logic [POS_W-1:0]        pos;
    int unsigned             roll;
    bit                      filling;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. First everything that can be asked of an empty list.
    send_request(OP_GET,    32'sd0,  4'd0);
    send_request(OP_REMOVE, 32'sd5,  4'd0);
    send_request(OP_UNUSED, -32'sd1, 4'd15);

    // The value extremes, with the largest value twice so that the remove
    // below has to pick the first of two matches.
    send_request(OP_APPEND, 32'sh7FFF_FFFF, 4'd0);
    send_request(OP_APPEND, 32'sh8000_0000, 4'd15);
    send_request(OP_APPEND, 32'sh0000_0000, 4'd0);
    send_request(OP_APPEND, 32'sh7FFF_FFFF, 4'd0);
    send_request(OP_GET,    32'sd0, 4'd0);
    send_request(OP_GET,    32'sd0, 4'd3);
    send_request(OP_GET,    -32'sd1, 4'd4);   // one past the tail

    // Remove at the head, then read back where the duplicate ended up.
    send_request(OP_REMOVE, 32'sh7FFF_FFFF, 4'd0);
    send_request(OP_GET,    32'sd0, 4'd2);
    send_request(OP_REMOVE, 32'sd999, 4'd0);  // no match anywhere

    // Fill the list to capacity, then push past it.
    send_request(OP_APPEND, -32'sd1, 4'd0);
    last_val = '0;
    for (int k = 0; k < CAPACITY - 4; k++) begin
      last_val = $urandom;
      send_request(OP_APPEND, last_val, POS_W'(k));
    end
    send_request(OP_APPEND, 32'sd42, 4'd0);   // dropped, list full
    send_request(OP_GET,    32'sd0, 4'd15);   // last slot when full
    send_request(OP_REMOVE, last_val, 4'd0);  // remove at the tail

    // Random part. Phases alternate between filling and draining, so the
    // list swings between empty and full many times. Most values are taken
    // from the list itself or from a small recurring set, so that removals
    // and duplicates are common; the rest are fully random.
    filling = 1'b0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 48 == 0) filling = !filling;
      roll = $urandom_range(99);
      if (filling) begin
        op = (roll < 55) ? OP_APPEND : (roll < 75) ? OP_REMOVE :
             (roll < 95) ? OP_GET : OP_UNUSED;
      end else begin
        op = (roll < 20) ? OP_APPEND : (roll < 65) ? OP_REMOVE :
             (roll < 95) ? OP_GET : OP_UNUSED;
      end

      roll = $urandom_range(99);
      if (mirror.held > 0 && roll < 40) begin
        val = mirror.entries[$urandom_range(mirror.held - 1)];
      end else if (roll < 65) begin
        val = common_value();
      end else begin
        val = $urandom;
      end

      if (mirror.held > 0 && $urandom_range(99) < 70) begin
        pos = POS_W'($urandom_range(mirror.held - 1));
      end else begin
        pos = POS_W'($urandom_range(15));
      end

      send_request(op, val, pos);
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then give the block time to
    // show any result that should not be there.
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (3 * CAPACITY + 8) @(posedge clk);
    if (mirror.due_results.size() != 0) begin
      $error("%0d requests left without a result", mirror.due_results.size());
      mirror.errors++;
    end

    if (mirror.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
